@@ sv/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap frame allocator
// Operation and status codes, register indexes, map word geometry and the
// find-first-zero helper used by the allocation scan.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    // default map size in frames
    localparam int NUM_FRAMES_DEF = 4096;

    // frame and map word geometry
    localparam int FRAME_SHIFT = 12;
    localparam int WORD_BITS   = 32;
    localparam int WORD_SHIFT  = 5;
    localparam int ADDR_BITS   = 32;
    localparam int FADDR_BITS  = 24;

    // configuration registers
    localparam int REG_BITS  = 13;
    localparam int APB_DATA  = 32;
    localparam int APB_ADDR  = 3;
    localparam int REG_SEL   = 2;     // paddr bit that picks the register

    typedef enum logic {
        REG_START = 1'b0,
        REG_END   = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOT_INIT = 2'd1,
        STAT_NO_FREE  = 2'd2,
        STAT_BEYOND   = 2'd3
    } t_status;

    // index of the lowest clear bit of a map word
    function automatic logic [WORD_SHIFT-1:0] find_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_SHIFT-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = WORD_SHIFT'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ sv/bitmap_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: one-bit-per-frame use map for 4096-byte frames
// Init rebuilds the map over a configured frame range, alloc hands out the
// lowest free frame, free returns a frame by byte address.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_operation, i_address
//  out     | output    | o_out_valid / i_out_ready | o_frame_address, o_status
//  config  | input     | psel, penable, pwrite     | paddr, pwdata, prdata
//
//  The map sits in a 32-bit-wide memory, one read and one write port, and a
//  single word datapath walks it under a small sequencer; one item at a time.
//  Init: writes the map from word 0 upward, one word written per cycle.
//  Alloc: scans map words upward from the lowest-candidate hint.
//  Free: read, modify-write, respond; other beats go straight to respond.
//  Synchronous active-low reset clears control state and the ready flag; the
//  map needs no clearing since nothing reads it before an init rewrites it.
//  A result stalled on the output holds the sequencer in its respond state.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator #(
    parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_operation,
    input  wire logic [bfa_pkg::ADDR_BITS-1:0]     i_address,
    // response channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [bfa_pkg::FADDR_BITS-1:0]         o_frame_address,
    output logic [1:0]                             o_status,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bfa_pkg::APB_ADDR-1:0]      paddr,
    input  wire logic [bfa_pkg::APB_DATA-1:0]      pwdata,
    output logic [bfa_pkg::APB_DATA-1:0]           prdata,
    output logic                                   pready
);

    localparam int WB  = bfa_pkg::WORD_BITS;
    localparam int WS  = bfa_pkg::WORD_SHIFT;
    localparam int FS  = bfa_pkg::FRAME_SHIFT;
    localparam int NW  = (NUM_FRAMES + WB - 1) / WB;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int CW  = ($clog2(NUM_FRAMES + 1) > bfa_pkg::REG_BITS)
                         ? $clog2(NUM_FRAMES + 1) : bfa_pkg::REG_BITS;
    localparam int DW  = CW - WS;
    localparam int FIW = bfa_pkg::ADDR_BITS - FS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_SCAN = 5'b00100,
        S_FREE = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_ready, n_ready;
    logic [AW:0]                    r_hint, n_hint;
    logic [AW-1:0]                  r_cidx, n_cidx;
    logic [WS-1:0]                  r_bit, n_bit;
    logic [CW-1:0]                  r_lo, n_lo;
    logic [CW-1:0]                  r_hi, n_hi;
    logic [bfa_pkg::FADDR_BITS-1:0] r_res_faddr, n_res_faddr;
    bfa_pkg::t_status               r_res_status, n_res_status;
    logic                           r_out_valid, n_out_valid;
    logic [bfa_pkg::FADDR_BITS-1:0] r_out_faddr, n_out_faddr;
    bfa_pkg::t_status               r_out_status, n_out_status;
    logic [bfa_pkg::REG_BITS-1:0]   r_start;
    logic [bfa_pkg::REG_BITS-1:0]   r_end;

    // map memory
    logic [WB-1:0]                  r_mem [NW];
    logic [WB-1:0]                  r_rdata;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [WB-1:0]                  wr_data;

    // decode helpers
    logic                           in_fire;
    logic                           out_free;
    logic [FIW-1:0]                 free_frame;
    logic                           free_beyond;
    logic [AW-1:0]                  free_word;
    logic [CW-1:0]                  end_ext;
    logic [DW-1:0]                  cur_w;
    logic [WB-1:0]                  ge_mask;
    logic [WB-1:0]                  lt_mask;
    logic [WB-1:0]                  ones;
    logic [WS-1:0]                  zero_bit;
    logic [AW+WS-1:0]               alloc_frame;

    assign ones        = '1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign free_frame  = i_address[bfa_pkg::ADDR_BITS-1:FS];
    assign free_beyond = {1'b0, free_frame} >= (FIW + 1)'(NUM_FRAMES);
    assign free_word   = i_address[FS+WS+AW-1:FS+WS];
    assign end_ext     = CW'(r_end);
    assign zero_bit    = bfa_pkg::find_zero(r_rdata);
    assign alloc_frame = {r_cidx, zero_bit};

    // free-range masks for the word being written during init
    always_comb begin
        cur_w = DW'(r_cidx);
        if (cur_w > r_lo[CW-1:WS]) begin
            ge_mask = ones;
        end else if (cur_w == r_lo[CW-1:WS]) begin
            ge_mask = ones << r_lo[WS-1:0];
        end else begin
            ge_mask = '0;
        end
        if (cur_w < r_hi[CW-1:WS]) begin
            lt_mask = ones;
        end else if (cur_w == r_hi[CW-1:WS]) begin
            lt_mask = ~(ones << r_hi[WS-1:0]);
        end else begin
            lt_mask = '0;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_ready      = r_ready;
        n_hint       = r_hint;
        n_cidx       = r_cidx;
        n_bit        = r_bit;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_faddr  = r_res_faddr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_faddr  = r_out_faddr;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = r_cidx;
        wr_en        = 1'b0;
        wr_addr      = r_cidx;
        wr_data      = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_faddr  = '0;
                    n_res_status = bfa_pkg::STAT_OK;
                    n_state      = S_RESP;
                    case (bfa_pkg::t_op'(i_operation))
                        bfa_pkg::OP_INIT: begin
                            n_lo    = CW'(r_start);
                            n_hi    = (end_ext > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : end_ext;
                            n_cidx  = '0;
                            n_state = S_INIT;
                        end
                        bfa_pkg::OP_ALLOC: begin
                            if (!r_ready) begin
                                n_res_status = bfa_pkg::STAT_NOT_INIT;
                            end else if (r_hint == (AW + 1)'(NW)) begin
                                n_res_status = bfa_pkg::STAT_NO_FREE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_hint[AW-1:0];
                                n_cidx  = r_hint[AW-1:0];
                                n_state = S_SCAN;
                            end
                        end
                        bfa_pkg::OP_FREE: begin
                            if (!r_ready) begin
                                n_res_status = bfa_pkg::STAT_NOT_INIT;
                            end else if (free_beyond) begin
                                n_res_status = bfa_pkg::STAT_BEYOND;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = free_word;
                                n_cidx  = free_word;
                                n_bit   = i_address[FS+WS-1:FS];
                                n_state = S_FREE;
                            end
                        end
                        default: begin
                            n_res_status = bfa_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            S_INIT: begin
                // one map word per cycle, used outside the free range
                wr_en   = 1'b1;
                wr_data = ~(ge_mask & lt_mask);
                if (r_cidx == AW'(NW - 1)) begin
                    n_ready = 1'b1;
                    n_hint  = ({1'b0, r_lo[CW-1:WS]} < (DW + 1)'(NW))
                              ? (AW + 1)'(r_lo[CW-1:WS]) : (AW + 1)'(NW);
                    n_state = S_RESP;
                end else begin
                    n_cidx = r_cidx + 1'b1;
                end
            end
            S_SCAN: begin
                // check the word read last cycle, fetch the next one
                if (r_rdata != ones) begin
                    wr_en       = 1'b1;
                    wr_data     = r_rdata | (WB'(1) << zero_bit);
                    n_hint      = {1'b0, r_cidx};
                    n_res_faddr = bfa_pkg::FADDR_BITS'({alloc_frame, {FS{1'b0}}});
                    n_state     = S_RESP;
                end else if (r_cidx == AW'(NW - 1)) begin
                    n_hint       = (AW + 1)'(NW);
                    n_res_status = bfa_pkg::STAT_NO_FREE;
                    n_state      = S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_cidx + 1'b1;
                    n_cidx  = r_cidx + 1'b1;
                end
            end
            S_FREE: begin
                wr_en   = 1'b1;
                wr_data = r_rdata & ~(WB'(1) << r_bit);
                if ({1'b0, r_cidx} < r_hint) begin
                    n_hint = {1'b0, r_cidx};
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_faddr  = r_res_faddr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
        end
        r_cidx       <= n_cidx;
        r_bit        <= n_bit;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_faddr  <= n_res_faddr;
        r_res_status <= n_res_status;
        r_out_faddr  <= n_out_faddr;
        r_out_status <= n_out_status;
    end

    // map memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (psel && penable && pwrite) begin
            case (bfa_pkg::t_reg'(paddr[bfa_pkg::REG_SEL]))
                bfa_pkg::REG_START: r_start <= pwdata[bfa_pkg::REG_BITS-1:0];
                bfa_pkg::REG_END:   r_end   <= pwdata[bfa_pkg::REG_BITS-1:0];
                default:            r_start <= r_start;
            endcase
        end
    end

    assign prdata = (bfa_pkg::t_reg'(paddr[bfa_pkg::REG_SEL]) == bfa_pkg::REG_END)
                    ? bfa_pkg::APB_DATA'(r_end) : bfa_pkg::APB_DATA'(r_start);
    assign pready = 1'b1;

    // ports
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_frame_address = r_out_faddr;
    assign o_status        = r_out_status;

`ifndef SYNTHESIS
    // a new response only comes out of the respond state
    a_resp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RESP))
        else $error("response raised outside respond state");

    // scan never walks past the last map word
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_cidx} < (AW + 1)'(NW)))
        else $error("scan index beyond map");

    // once initialized the map stays initialized
    a_ready_sticky: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> !$fell(r_ready))
        else $error("ready flag dropped without reset");

    // one request in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("request accepted while busy");
`endif

endmodule

`default_nettype wire

@@ verif/bitmap_frame_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb: self-checking bench for the frame allocator
// A directed pass covers requests before init, map exhaustion, the address
// extremes, an end frame past the map and an empty range. Random phases
// follow, each with its own frame range: allocations, frees of frames handed
// out, double frees, frees past the map, re-inits and reserved beats. Every
// request beat is predicted against a local copy of the use map, and every
// response beat is compared in order.
// ----------------------------------------------------------------------------

module bitmap_frame_allocator_tb;

    localparam int NF             = bfa_pkg::NUM_FRAMES_DEF;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 10;
    localparam int PHASE_BEATS    = 130;

    // one predicted response beat
    typedef struct {
        logic [bfa_pkg::FADDR_BITS-1:0] faddr;
        bfa_pkg::t_status               status;
    } t_grant;

    // use map copy, register copy and the responses still owed
    class t_frame_ledger;
        bit [NF-1:0]                   used_map;
        bit                            map_ready;
        logic [bfa_pkg::REG_BITS-1:0]  start_reg;
        logic [bfa_pkg::REG_BITS-1:0]  end_reg;
        int                            held_frames[$];
        t_grant                        owed[$];
        int                            errors;

        function new();
            used_map  = '1;
            map_ready = 1'b0;
            start_reg = '0;
            end_reg   = '0;
            errors    = 0;
        endfunction

        function void set_reg(bfa_pkg::t_reg r, logic [bfa_pkg::REG_BITS-1:0] v);
            if (r == bfa_pkg::REG_START) begin
                start_reg = v;
            end else begin
                end_reg = v;
            end
        endfunction

        // apply one request beat to the map and queue its response
        function void take_request(bfa_pkg::t_op op, logic [bfa_pkg::ADDR_BITS-1:0] addr);
            t_grant g;
            int     lim;
            int     f;
            int     i;
            g.faddr  = '0;
            g.status = bfa_pkg::STAT_OK;
            case (op)
                bfa_pkg::OP_INIT: begin
                    used_map = '1;
                    lim = (int'(end_reg) > NF) ? NF : int'(end_reg);
                    for (f = int'(start_reg); f < lim; f++) begin
                        used_map[f] = 1'b0;
                    end
                    map_ready = 1'b1;
                    held_frames.delete();
                end
                bfa_pkg::OP_ALLOC: begin
                    if (!map_ready) begin
                        g.status = bfa_pkg::STAT_NOT_INIT;
                    end else begin
                        f = 0;
                        while (f < NF && used_map[f]) begin
                            f++;
                        end
                        if (f < NF) begin
                            used_map[f] = 1'b1;
                            g.faddr = bfa_pkg::FADDR_BITS'(f << bfa_pkg::FRAME_SHIFT);
                            held_frames.push_back(f);
                        end else begin
                            g.status = bfa_pkg::STAT_NO_FREE;
                        end
                    end
                end
                bfa_pkg::OP_FREE: begin
                    f = int'(addr >> bfa_pkg::FRAME_SHIFT);
                    if (!map_ready) begin
                        g.status = bfa_pkg::STAT_NOT_INIT;
                    end else if (f >= NF) begin
                        g.status = bfa_pkg::STAT_BEYOND;
                    end else begin
                        used_map[f] = 1'b0;
                        for (i = 0; i < held_frames.size(); i++) begin
                            if (held_frames[i] == f) begin
                                held_frames.delete(i);
                                break;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            owed.push_back(g);
        endfunction

        // compare one response beat with the oldest prediction
        function void match_response(logic [bfa_pkg::FADDR_BITS-1:0] faddr,
                                     logic [1:0] status);
            t_grant g;
            if (owed.size() == 0) begin
                $display("%0t: response beat with nothing owed: frame_address %h status %0d",
                         $time, faddr, status);
                errors++;
                return;
            end
            g = owed.pop_front();
            if (faddr !== g.faddr) begin
                $display("%0t: frame_address mismatch: expected %h actual %h",
                         $time, g.faddr, faddr);
                errors++;
            end
            if (status !== g.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, g.status, status);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // block inputs, all known from time zero
    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic [1:0]                       i_operation = bfa_pkg::OP_INIT;
    logic [bfa_pkg::ADDR_BITS-1:0]    i_address   = '0;
    logic                             i_out_ready = 1'b0;
    logic                             psel        = 1'b0;
    logic                             penable     = 1'b0;
    logic                             pwrite      = 1'b0;
    logic [bfa_pkg::APB_ADDR-1:0]     paddr       = '0;
    logic [bfa_pkg::APB_DATA-1:0]     pwdata      = '0;

    // block outputs
    logic                             o_in_ready;
    logic                             o_out_valid;
    logic [bfa_pkg::FADDR_BITS-1:0]   o_frame_address;
    logic [1:0]                       o_status;
    logic [bfa_pkg::APB_DATA-1:0]     prdata;
    logic                             pready;

    t_frame_ledger ledger = new();
    int            hold_asked  = 0;
    int            hold_served = 0;

    bitmap_frame_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_address       (i_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_address (o_frame_address),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // response beats go to the ledger
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            ledger.match_response(o_frame_address, o_status);
        end
    end

    // offer one request beat and wait until it is taken
    task automatic send_item(bfa_pkg::t_op op, logic [bfa_pkg::ADDR_BITS-1:0] addr);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_address   <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.take_request(op, addr);
    endtask

    task automatic idle_in(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until every predicted response has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (ledger.pending() > 0) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, then idle
    task automatic write_reg(bfa_pkg::t_reg r, logic [bfa_pkg::REG_BITS-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bfa_pkg::APB_ADDR'(r) << bfa_pkg::REG_SEL;
        pwdata  <= bfa_pkg::APB_DATA'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ledger.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int first, int last);
        drain();
        write_reg(bfa_pkg::REG_START, bfa_pkg::REG_BITS'(first));
        write_reg(bfa_pkg::REG_END, bfa_pkg::REG_BITS'(last));
    endtask

    // random traffic in bursts; mostly allocs and frees of frames handed out
    task automatic run_random(int count, bit with_hold);
        int                            k;
        int                            burst_left;
        int                            sel;
        int                            f;
        logic [bfa_pkg::ADDR_BITS-1:0] a;
        bfa_pkg::t_op                  op;
        burst_left = 0;
        for (k = 0; k < count; k++) begin
            if (burst_left == 0) begin
                idle_in(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if (with_hold && k == 30) begin
                hold_asked++;
            end
            sel = $urandom_range(0, 99);
            a   = $urandom;
            if (sel < 45) begin
                op = bfa_pkg::OP_ALLOC;
            end else if (sel < 70) begin
                op = bfa_pkg::OP_FREE;
                if (ledger.held_frames.size() > 0) begin
                    f = ledger.held_frames[$urandom_range(0, ledger.held_frames.size() - 1)];
                    a = (bfa_pkg::ADDR_BITS'(f) << bfa_pkg::FRAME_SHIFT)
                        | (a & 32'h0000_0FFF);
                end
            end else if (sel < 80) begin
                // any frame inside the map, double frees included
                op = bfa_pkg::OP_FREE;
                a  = $urandom_range(0, 32'h00FF_FFFF);
            end else if (sel < 88) begin
                op = bfa_pkg::OP_FREE;
            end else if (sel < 92) begin
                op = bfa_pkg::OP_INIT;
            end else begin
                op = bfa_pkg::OP_RSVD;
            end
            send_item(op, a);
        end
    endtask

    // response side stalls; a requested long hold-off fills the block up
    initial begin : out_stall
        int run_left;
        int mode;
        int hold_left;
        run_left  = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = LONG_HOLD;
            end
            if (run_left == 0) begin
                mode     = $urandom_range(0, 3);
                run_left = $urandom_range(8, 60);
            end
            run_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 1) == 1);
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    // main sequence
    initial begin : stimulus
        int p;
        int first;
        int last;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // requests before any init
        send_item(bfa_pkg::OP_ALLOC, $urandom);
        send_item(bfa_pkg::OP_FREE, 32'h0000_0000);
        send_item(bfa_pkg::OP_RSVD, 32'hFFFF_FFFF);

        // four frames: exhaust, refill, address extremes, rebuild
        configure(0, 4);
        send_item(bfa_pkg::OP_INIT, 32'hFFFF_FFFF);
        repeat (5) send_item(bfa_pkg::OP_ALLOC, $urandom);
        send_item(bfa_pkg::OP_FREE, 32'h0000_1FFF);
        send_item(bfa_pkg::OP_ALLOC, $urandom);
        send_item(bfa_pkg::OP_FREE, 32'hFFFF_FFFF);
        send_item(bfa_pkg::OP_FREE, 32'h0100_0000);
        send_item(bfa_pkg::OP_FREE, 32'h00FF_FFFF);
        send_item(bfa_pkg::OP_ALLOC, $urandom);
        send_item(bfa_pkg::OP_INIT, 32'h0000_0000);
        send_item(bfa_pkg::OP_ALLOC, $urandom);

        // end frame past the map gets clamped
        configure(4090, 8191);
        send_item(bfa_pkg::OP_INIT, $urandom);
        repeat (7) send_item(bfa_pkg::OP_ALLOC, $urandom);

        // empty range still marks the map ready
        configure(100, 50);
        send_item(bfa_pkg::OP_INIT, $urandom);
        send_item(bfa_pkg::OP_ALLOC, $urandom);

        // random phases, each with its own frame range
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin first = 0;    last = NF;   end
                1: begin first = 0;    last = 0;    end
                2: begin first = NF;   last = NF;   end
                3: begin first = 0;    last = 8191; end
                4: begin first = NF-1; last = NF;   end
                default: begin
                    first = $urandom_range(0, NF - 10);
                    last  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, first)
                                                        : first + $urandom_range(1, 60);
                end
            endcase
            configure(first, last);
            send_item(bfa_pkg::OP_INIT, $urandom);
            run_random(PHASE_BEATS, p == 6);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
